// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL modules (included by scu_ctrl).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/scu_pkg.sv =====
// Package: sizes, types and state codes of the set intersection core.
`default_nettype none

package scu_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE
    } t_state;

    typedef struct packed {
        logic              reported;
        logic [DATA_W-1:0] value;
    } t_word;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_word            data;
    } t_mem_wr;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              new_match;
        logic              set_full;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/scu_ram.sv =====
// Simple dual-port RAM, one write and one registered read per cycle.
`default_nettype none

module scu_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 33
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output      logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/scu_ctrl.sv =====
// Scan controller: searches the stored entries, then updates them and forms the result.
`default_nettype none

`include "assert_macros.svh"

module scu_ctrl (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic                         i_mode,
    input  wire logic [scu_pkg::DATA_W-1:0]   i_item_value,
    input  wire logic                         i_last,
    output      logic                         o_busy,
    output      logic                         o_rd_en,
    output      logic [scu_pkg::IDX_W-1:0]    o_rd_addr,
    input  wire scu_pkg::t_word               i_rd_data,
    output      scu_pkg::t_mem_wr             o_wr,
    output      scu_pkg::t_result             o_res,
    output      logic                         o_res_stb
);

    scu_pkg::t_state                r_state;
    scu_pkg::t_state                n_state;
    logic                           r_mode;
    logic [scu_pkg::DATA_W-1:0]     r_val;
    logic                           r_last;
    logic [scu_pkg::CNT_W-1:0]      r_count;
    logic [scu_pkg::CNT_W-1:0]      n_count;
    logic [scu_pkg::CNT_W-1:0]      r_rd_idx;
    logic                           r_cmp_v;
    logic [scu_pkg::IDX_W-1:0]      r_cmp_idx;
    logic                           r_hit;
    logic [scu_pkg::IDX_W-1:0]      r_hit_idx;
    logic                           r_hit_rep;

    logic accept;
    logic rd_live;
    logic cmp_hit;
    logic has_room;

    assign accept   = i_start && (r_state == scu_pkg::S_IDLE);
    assign rd_live  = r_rd_idx < r_count;
    assign cmp_hit  = r_cmp_v && (i_rd_data.value == r_val);
    assign has_room = r_count < scu_pkg::CNT_W'(scu_pkg::CAPACITY);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            scu_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = scu_pkg::S_SCAN;
                end
            end
            scu_pkg::S_SCAN: begin
                if (cmp_hit || !rd_live) begin
                    n_state = scu_pkg::S_UPDATE;
                end
            end
            scu_pkg::S_UPDATE: begin
                n_state = scu_pkg::S_IDLE;
            end
            default: begin
                n_state = scu_pkg::S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_busy          = 1'b1;
        o_rd_en         = 1'b0;
        o_rd_addr       = r_rd_idx[scu_pkg::IDX_W-1:0];
        o_wr            = '0;
        o_res.value     = r_val;
        o_res.new_match = 1'b0;
        o_res.set_full  = 1'b0;
        o_res_stb       = 1'b0;
        n_count         = r_count;
        case (r_state)
            scu_pkg::S_IDLE: begin
                o_busy = 1'b0;
            end
            scu_pkg::S_SCAN: begin
                o_rd_en = rd_live && !cmp_hit;
            end
            scu_pkg::S_UPDATE: begin
                o_res_stb = 1'b1;
                if (!r_mode) begin
                    if (!r_hit && has_room) begin
                        o_wr.en            = 1'b1;
                        o_wr.addr          = r_count[scu_pkg::IDX_W-1:0];
                        o_wr.data.reported = 1'b0;
                        o_wr.data.value    = r_val;
                        n_count            = r_count + scu_pkg::CNT_W'(1);
                    end
                    o_res.set_full = !r_hit && !has_room;
                end else begin
                    if (r_hit && !r_hit_rep) begin
                        o_wr.en            = 1'b1;
                        o_wr.addr          = r_hit_idx;
                        o_wr.data.reported = 1'b1;
                        o_wr.data.value    = r_val;
                        o_res.new_match    = 1'b1;
                    end
                    if (r_last) begin
                        n_count = '0;
                    end
                end
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scu_pkg::S_IDLE;
            r_count <= '0;
            r_cmp_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (accept) begin
                r_cmp_v <= 1'b0;
            end else if (r_state == scu_pkg::S_SCAN) begin
                r_cmp_v <= o_rd_en;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode   <= i_mode;
            r_val    <= i_item_value;
            r_last   <= i_last;
            r_rd_idx <= '0;
        end else if (r_state == scu_pkg::S_SCAN) begin
            r_cmp_idx <= r_rd_idx[scu_pkg::IDX_W-1:0];
            r_hit     <= cmp_hit;
            r_hit_rep <= i_rd_data.reported;
            if (cmp_hit) begin
                r_hit_idx <= r_cmp_idx;
            end
            if (o_rd_en) begin
                r_rd_idx <= r_rd_idx + scu_pkg::CNT_W'(1);
            end
        end
    end

    `ASSERT_CLK(a_wr_only_in_update, o_wr.en |-> (r_state == scu_pkg::S_UPDATE), "write outside update")
    `ASSERT_CLK(a_idle_after_result, o_res_stb |=> (r_state == scu_pkg::S_IDLE), "no idle after result")
    `ASSERT_CLK(a_insert_grows_count, (o_wr.en && !r_mode) |=> (r_count == $past(r_count) + scu_pkg::CNT_W'(1)), "count not incremented")
    `ASSERT_CLK(a_match_full_excl, o_res_stb |-> !(o_res.new_match && o_res.set_full), "match and full together")
    `ASSERT_CLK_ALWAYS(a_no_read_in_update, (r_state == scu_pkg::S_UPDATE) |-> !o_rd_en, "read during update")

endmodule

`default_nettype wire

// ===== rtl/set_intersection_unique_core.sv =====
// Top level of the set intersection core: entry memory, scan controller, result register.
//
// Usage:
//   Input: drive i_mode, i_item_value and i_last with start high; the transaction
//   is taken at the rising edge where start is high and busy is low. Mode 0 inserts
//   the value into the set, mode 1 probes it; last on a probe empties the set
//   after that probe's result.
//   Output: each transaction gives one result, shown for exactly one cycle with
//   o_result_strobe high. The receiver cannot stall and must take it then.
//   Timing: a transaction keeps busy high from the accepting edge through the scan
//   of the stored values and the update state; a hit ends the scan early. The
//   result strobe is registered and rises in the cycle after the update. A new
//   transaction can be accepted in the cycle the previous result is shown. The
//   scan rate is set by the entry memory's single read port, one stored entry per cycle.
//   Reset (synchronous, active low) empties the set and returns to idle; the
//   memory itself is not cleared, entries above the fill count are never read.
`default_nettype none

module set_intersection_unique_core (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output      logic                       busy,
    input  wire logic                       i_mode,
    input  wire logic signed [31:0]         i_item_value,
    input  wire logic                       i_last,
    output      logic                       o_result_strobe,
    output      logic signed [31:0]         o_result_value,
    output      logic                       o_new_match,
    output      logic                       o_set_full
);

    logic                        rd_en;
    logic [scu_pkg::IDX_W-1:0]   rd_addr;
    scu_pkg::t_word              rd_data;
    scu_pkg::t_mem_wr            wr;
    scu_pkg::t_result            res;
    logic                        res_stb;

    logic                        r_stb;
    scu_pkg::t_result            r_res;

    scu_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_mode       (i_mode),
        .i_item_value (i_item_value),
        .i_last       (i_last),
        .o_busy       (busy),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data),
        .o_wr         (wr),
        .o_res        (res),
        .o_res_stb    (res_stb)
    );

    scu_ram #(
        .DEPTH (scu_pkg::CAPACITY),
        .AW    (scu_pkg::IDX_W),
        .DW    ($bits(scu_pkg::t_word))
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr.en),
        .i_waddr (wr.addr),
        .i_wdata (wr.data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stb <= 1'b0;
        end else begin
            r_stb <= res_stb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_stb) begin
            r_res <= res;
        end
    end

    assign o_result_strobe = r_stb;
    assign o_result_value  = r_res.value;
    assign o_new_match     = r_res.new_match;
    assign o_set_full      = r_res.set_full;

endmodule

`default_nettype wire

// ===== dv/set_intersection_unique_core_tb.sv =====
// Testbench for set_intersection_unique_core: self-checking insert/probe traffic.
`timescale 1ns / 100ps

module set_intersection_unique_core_tb;

    localparam bit MODE_INSERT = 1'b0;
    localparam bit MODE_PROBE  = 1'b1;
    localparam int ITEM_TARGET = 1050;
    localparam int CYCLE_LIMIT = 400_000;
    localparam int DRAIN_CYCLES = scu_pkg::CAPACITY + 8;

    class set_match_scoreboard;
        logic [scu_pkg::DATA_W-1:0] stored_value [scu_pkg::CAPACITY];
        bit                         stored_valid [scu_pkg::CAPACITY];
        bit                         stored_reported [scu_pkg::CAPACITY];
        int unsigned                stored_count;
        scu_pkg::t_result           expected_q[$];
        int                         errors;

        function void clear_entries();
            foreach (stored_valid[i]) begin
                stored_valid[i]    = 1'b0;
                stored_reported[i] = 1'b0;
            end
            stored_count = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_transaction(bit mode, logic [scu_pkg::DATA_W-1:0] value, bit last);
            scu_pkg::t_result exp_res;
            int hit;
            hit = -1;
            for (int i = 0; i < scu_pkg::CAPACITY; i++) begin
                if (hit < 0 && stored_valid[i] && stored_value[i] == value) begin
                    hit = i;
                end
            end
            exp_res.value     = value;
            exp_res.new_match = 1'b0;
            exp_res.set_full  = 1'b0;
            if (mode == MODE_INSERT) begin
                if (hit < 0) begin
                    if (stored_count < scu_pkg::CAPACITY) begin
                        stored_value[stored_count]    = value;
                        stored_valid[stored_count]    = 1'b1;
                        stored_reported[stored_count] = 1'b0;
                        stored_count++;
                    end else begin
                        exp_res.set_full = 1'b1;
                    end
                end
            end else begin
                if (hit >= 0 && !stored_reported[hit]) begin
                    stored_reported[hit] = 1'b1;
                    exp_res.new_match    = 1'b1;
                end
                if (last) begin
                    clear_entries();
                end
            end
            expected_q = {expected_q, exp_res};
        endfunction

        function void check_result(logic [scu_pkg::DATA_W-1:0] value, logic new_match,
                                   logic set_full);
            scu_pkg::t_result exp_res;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result value=%h match=%b full=%b",
                         $time, value, new_match, set_full);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            if (value !== exp_res.value) begin
                $display("%0t: result_value expected %h actual %h",
                         $time, exp_res.value, value);
                errors++;
            end
            if (new_match !== exp_res.new_match) begin
                $display("%0t: new_match expected %b actual %b (value %h)",
                         $time, exp_res.new_match, new_match, exp_res.value);
                errors++;
            end
            if (set_full !== exp_res.set_full) begin
                $display("%0t: set_full expected %b actual %b (value %h)",
                         $time, exp_res.set_full, set_full, exp_res.value);
                errors++;
            end
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic                       i_mode = 1'b0;
    logic [scu_pkg::DATA_W-1:0] i_item_value = '0;
    logic                       i_last = 1'b0;
    logic                       o_result_strobe;
    logic [scu_pkg::DATA_W-1:0] o_result_value;
    logic                       o_new_match;
    logic                       o_set_full;

    set_match_scoreboard        sb = new();
    int                         items_sent = 0;
    int                         cycle_count = 0;
    bit                         idle_on = 1'b1;
    logic [scu_pkg::DATA_W-1:0] inserted_q[$];

    set_intersection_unique_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_mode          (i_mode),
        .i_item_value    (i_item_value),
        .i_last          (i_last),
        .o_result_strobe (o_result_strobe),
        .o_result_value  (o_result_value),
        .o_new_match     (o_new_match),
        .o_set_full      (o_set_full)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                sb.note_transaction(i_mode, i_item_value, i_last);
            end
            if (o_result_strobe) begin
                sb.check_result(o_result_value, o_new_match, o_set_full);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_item(input bit mode, input logic [scu_pkg::DATA_W-1:0] value,
                             input bit last);
        if (idle_on && $urandom_range(0, 99) < 35) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_mode       <= mode;
        i_item_value <= value;
        i_last       <= last;
        do @(posedge i_clk); while (busy);
        items_sent++;
        if (mode == MODE_PROBE && last) begin
            inserted_q.delete();
        end else if (mode == MODE_INSERT) begin
            inserted_q = {inserted_q, value};
        end
    endtask

    // hold off new transactions until every expected result is back
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    function automatic logic [scu_pkg::DATA_W-1:0] pick_insert_value(
        logic [scu_pkg::DATA_W-1:0] base, bit fill);
        int sel;
        sel = $urandom_range(0, 9);
        if (fill) begin
            if (sel == 0 && inserted_q.size() != 0) begin
                return inserted_q[$urandom_range(0, inserted_q.size() - 1)];
            end
            return $urandom;
        end
        if (sel < 6) begin
            return base + $urandom_range(0, 23);
        end else if (sel < 8) begin
            return $urandom;
        end
        case ($urandom_range(0, 3))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h7FFF_FFFF;
            default: return 32'h8000_0000;
        endcase
    endfunction

    task automatic run_round();
        logic [scu_pkg::DATA_W-1:0] base;
        logic [scu_pkg::DATA_W-1:0] value;
        bit                         fill;
        bit                         last;
        int                         n_ins;
        int                         n_probe;
        base  = $urandom;
        fill  = ($urandom_range(0, 9) == 0);
        n_ins = fill ? $urandom_range(64, 72) : $urandom_range(1, 20);
        for (int i = 0; i < n_ins; i++) begin
            value = pick_insert_value(base, fill);
            if ($urandom_range(0, 24) == 0) begin
                send_item(MODE_PROBE, value, 1'b0);
            end else begin
                send_item(MODE_INSERT, value, $urandom_range(0, 19) == 0);
            end
        end
        n_probe = $urandom_range(1, 20);
        for (int i = 0; i < n_probe; i++) begin
            if ($urandom_range(0, 3) != 0 && inserted_q.size() != 0) begin
                value = inserted_q[$urandom_range(0, inserted_q.size() - 1)];
            end else begin
                value = $urandom;
            end
            if (i == n_probe - 1) begin
                last = ($urandom_range(0, 7) != 0);
            end else begin
                last = ($urandom_range(0, 39) == 0);
            end
            send_item(MODE_PROBE, value, last);
        end
        if ($urandom_range(0, 7) == 0) begin
            drain();
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(MODE_INSERT, 32'h0000_0000, 1'b0);
        send_item(MODE_INSERT, 32'hFFFF_FFFF, 1'b0);
        send_item(MODE_INSERT, 32'h7FFF_FFFF, 1'b0);
        send_item(MODE_INSERT, 32'h8000_0000, 1'b0);
        send_item(MODE_INSERT, 32'h0000_0000, 1'b0);
        send_item(MODE_INSERT, 32'h1234_5678, 1'b1);
        send_item(MODE_PROBE,  32'h7FFF_FFFF, 1'b0);
        send_item(MODE_PROBE,  32'h7FFF_FFFF, 1'b0);
        send_item(MODE_PROBE,  32'h0000_0005, 1'b0);
        send_item(MODE_PROBE,  32'h1234_5678, 1'b0);
        send_item(MODE_PROBE,  32'hFFFF_FFFF, 1'b0);
        send_item(MODE_PROBE,  32'h8000_0000, 1'b1);
        send_item(MODE_PROBE,  32'h0000_0000, 1'b0);
        send_item(MODE_PROBE,  32'h0000_0000, 1'b1);
        send_item(MODE_INSERT, 32'h0000_0000, 1'b0);
        drain();

        while (items_sent < ITEM_TARGET) begin
            idle_on = !(items_sent >= 450 && items_sent < 650);
            run_round();
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
